@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TBT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TBT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TBT_ASSERT(name, clk, rst_n, prop, msg)
`define TBT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

@@ sv/tbt_pkg.sv @@
// ----------------------------------------------------------------------------
// Token bucket table package
// Request and response types, operation and status codes, control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbt_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 64;
  localparam int unsigned ENTRY_W         = 48;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ALLOC  = 3'd1;
  localparam logic [2:0] MODE_FETCH  = 3'd2;
  localparam logic [2:0] MODE_RETURN = 3'd3;
  localparam logic [2:0] MODE_FREE   = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_ZERO   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_UNUSED = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  bucket_index;
    logic [15:0] amount;
    logic [15:0] rate;
    logic [15:0] burst_limit;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted;
    logic [5:0]  slot;
  } rsp_t;

  typedef struct packed {
    logic req_ld;
    logic res_early;
    logic rd_idx;
    logic rd_cnt;
    logic mod_wr;
    logic tick_wr;
    logic alloc_wr;
    logic alloc_full;
    logic live_clr;
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       early_ok;
    logic       cnt_live;
    logic       cnt_last;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ sv/tbt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tbt_datapath.sv @@
// ----------------------------------------------------------------------------
// Token bucket datapath
// Request latch, live bits, bucket RAM, update arithmetic, result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbt_datapath #(
  parameter int unsigned NUM_BUCKETS = tbt_pkg::NUM_BUCKETS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbt_pkg::req_t      in_req_i,
  input  tbt_pkg::ctrl_cmd_t cmd_i,
  output tbt_pkg::dp_sts_t   sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tbt_pkg::rsp_t      out_rsp_o
);

  import tbt_pkg::*;

  localparam int unsigned IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  req_t                   req_q;
  rsp_t                   res_q;
  rsp_t                   rsp_q;
  logic                   out_valid_q;
  logic [NUM_BUCKETS-1:0] live_q;
  logic [IDX_W-1:0]       cnt_q;

  logic [IDX_W-1:0]   idx_a;
  logic               idx_ok;
  logic [2:0]         early_status;
  logic [ENTRY_W-1:0] rdata;
  logic [15:0]        cur_count;
  logic [15:0]        cur_ceil;
  logic [15:0]        cur_rate;
  logic [15:0]        add_opnd;
  logic [16:0]        sum;
  logic [15:0]        clamped;
  logic [15:0]        grant;
  logic               is_fetch;
  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign idx_a  = IDX_W'(req_q.bucket_index);
  assign idx_ok = (32'(req_q.bucket_index) < NUM_BUCKETS) && live_q[idx_a];

  always_comb begin
    early_status = ST_OK;
    unique case (req_q.mode) inside
      MODE_FETCH, MODE_RETURN: begin
        if (req_q.amount == 16'd0) begin
          early_status = ST_ZERO;
        end else if (!idx_ok) begin
          early_status = ST_UNUSED;
        end
      end
      MODE_FREE: begin
        if (!idx_ok) begin
          early_status = ST_UNUSED;
        end
      end
      default: early_status = ST_OK;
    endcase
  end

  assign cur_count = rdata[15:0];
  assign cur_ceil  = rdata[31:16];
  assign cur_rate  = rdata[47:32];
  assign is_fetch  = (req_q.mode == MODE_FETCH);

  assign add_opnd = cmd_i.tick_wr ? cur_rate : req_q.amount;
  assign sum      = {1'b0, cur_count} + {1'b0, add_opnd};
  assign clamped  = (sum >= {1'b0, cur_ceil}) ? cur_ceil : sum[15:0];
  assign grant    = (cur_count < req_q.amount) ? cur_count : req_q.amount;

  assign ram_re    = cmd_i.rd_idx || cmd_i.rd_cnt;
  assign ram_raddr = cmd_i.rd_cnt ? cnt_q : idx_a;
  assign ram_waddr = cmd_i.mod_wr ? idx_a : cnt_q;
  assign ram_we    = (cmd_i.mod_wr && (!is_fetch || cur_count != 16'd0))
                  || (cmd_i.tick_wr && live_q[cnt_q])
                  || cmd_i.alloc_wr;

  always_comb begin
    if (cmd_i.alloc_wr) begin
      ram_wdata = {req_q.rate, req_q.burst_limit, 16'd0};
    end else if (cmd_i.mod_wr && is_fetch) begin
      ram_wdata = {cur_rate, cur_ceil, cur_count - grant};
    end else begin
      ram_wdata = {cur_rate, cur_ceil, clamped};
    end
  end

  tbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUCKETS),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_ld) begin
      req_q <= in_req_i;
    end
    if (cmd_i.res_early) begin
      res_q <= '{status: early_status, granted: 16'd0, slot: req_q.bucket_index};
    end else if (cmd_i.mod_wr && is_fetch) begin
      if (cur_count == 16'd0) begin
        res_q.status <= ST_EMPTY;
      end else begin
        res_q.granted <= grant;
      end
    end else if (cmd_i.alloc_wr) begin
      res_q <= '{status: ST_OK, granted: 16'd0, slot: 6'(cnt_q)};
    end else if (cmd_i.alloc_full) begin
      res_q <= '{status: ST_FULL, granted: 16'd0, slot: 6'd0};
    end
    if (cmd_i.out_load) begin
      rsp_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.alloc_wr) begin
        live_q[cnt_q] <= 1'b1;
      end else if (cmd_i.live_clr) begin
        live_q[idx_a] <= 1'b0;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.mode     = req_q.mode;
  assign sts_o.early_ok = (early_status == ST_OK);
  assign sts_o.cnt_live = live_q[cnt_q];
  assign sts_o.cnt_last = (cnt_q == IDX_W'(NUM_BUCKETS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ sv/tbt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Token bucket controller
// Sequences each request: decode, RAM read-modify-write, table walks, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tbt_pkg::dp_sts_t   sts_i,
  output tbt_pkg::ctrl_cmd_t cmd_o
);

  import tbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_TICK_RD,
    S_TICK_WR,
    S_ALLOC,
    S_DONE
  } state_e;

  state_e state_d, state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_ld = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.res_early = 1'b1;
        unique case (sts_i.mode) inside
          MODE_TICK: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_TICK_RD;
          end
          MODE_ALLOC: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_ALLOC;
          end
          MODE_FETCH, MODE_RETURN: begin
            if (sts_i.early_ok) begin
              cmd_o.rd_idx = 1'b1;
              state_d      = S_MOD;
            end else begin
              state_d = S_DONE;
            end
          end
          MODE_FREE: begin
            cmd_o.live_clr = sts_i.early_ok;
            state_d        = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MOD: begin
        cmd_o.mod_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_TICK_RD: begin
        cmd_o.rd_cnt = 1'b1;
        state_d      = S_TICK_WR;
      end
      S_TICK_WR: begin
        cmd_o.tick_wr = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_TICK_RD;
        end
      end
      S_ALLOC: begin
        if (!sts_i.cnt_live) begin
          cmd_o.alloc_wr = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.cnt_last) begin
          cmd_o.alloc_full = 1'b1;
          state_d          = S_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TBT_ASSERT(a_accept_decodes, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_DECODE), "accepted request not decoded")
  `TBT_ASSERT(a_load_when_free, clk_i, rst_ni, cmd_o.out_load |-> sts_i.out_free, "result loaded over pending response")
  `TBT_ASSERT(a_tick_walk, clk_i, rst_ni, (state_q == S_TICK_WR && !sts_i.cnt_last) |=> (state_q == S_TICK_RD), "tick walk stopped early")
  `TBT_NEVER(a_one_ram_op, clk_i, rst_ni, (cmd_o.mod_wr || cmd_o.tick_wr) && cmd_o.alloc_wr, "conflicting RAM writes")

endmodule

@@ sv/token_bucket_table_top.sv @@
// ----------------------------------------------------------------------------
// Token bucket table
// Rate limiter with a table of buckets: tick, allocate, fetch, return, free.
// ----------------------------------------------------------------------------
//  channel  signals                        payload
//  request  in_valid_i / in_ready_o        in_req_i   (tbt_pkg::req_t)
//  response out_valid_o / out_ready_i      out_rsp_o  (tbt_pkg::rsp_t)
//
//  Fetch and return with a live slot: accept, decode with RAM read,
//  read-modify-write into the result stage, result load. Free, zero amount,
//  unused slot, unknown mode: accept, decode, result load.
//  Tick: accept, decode, one read and one write per slot, result load.
//  Allocate: accept, decode, one live bit checked per cycle, result load.
//  Reset clears the live bits at once; no clearing pass. One request at a time;
//  a finished result waits in the last state while the response is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_bucket_table_top #(
  parameter int unsigned NUM_BUCKETS = tbt_pkg::NUM_BUCKETS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tbt_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tbt_pkg::rsp_t out_rsp_o
);

  import tbt_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  tbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbt_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
